>>> design/rps_pkg.sv
// Shared types and constants for the roulette parent selector.
package rps_pkg;

   localparam int OBJ_W              = 32;
   localparam int FRAC_W             = 24;
   localparam int INDEX_W            = 6;
   localparam int MAX_POPULATION_DEF = 64;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_DRAW = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BUILD_RD,
      ST_BUILD_WR,
      ST_TOT_RD,
      ST_TOT_MUL,
      ST_NEED,
      ST_SRCH,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_accept;
      logic draw_accept;
      logic build_write;
      logic build_finish;
      logic tot_read;
      logic mul;
      logic need;
      logic srch_read;
      logic cmp;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic table_ready;
      logic build_done;
      logic srch_more;
      logic rsp_free;
   } status_type;

endpackage

>>> design/rps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rps_ram #(
   parameter int WIDTH = rps_pkg::OBJ_W,
   parameter int DEPTH = rps_pkg::MAX_POPULATION_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rps_ctrl.sv
// Controller state machine for the roulette parent selector.
module rps_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   input  logic                req_last,
   output logic                req_stall,
   input  rps_pkg::status_type status,
   output rps_pkg::cmd_type    cmd
);
   import rps_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_LOAD) begin
                  state_in = req_last ? ST_BUILD_RD : ST_IDLE;
               end else begin
                  state_in = status.table_ready ? ST_TOT_RD : ST_DONE;
               end
            end
         end
         ST_BUILD_RD: state_in = ST_BUILD_WR;
         ST_BUILD_WR: state_in = status.build_done ? ST_IDLE : ST_BUILD_RD;
         ST_TOT_RD:   state_in = ST_TOT_MUL;
         ST_TOT_MUL:  state_in = ST_NEED;
         ST_NEED:     state_in = ST_SRCH;
         ST_SRCH:     state_in = status.srch_more ? ST_CMP : ST_DONE;
         ST_CMP:      state_in = ST_SRCH;
         ST_DONE:     state_in = status.rsp_free ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            cmd.load_accept = req_valid && (req_mode == MODE_LOAD);
            cmd.draw_accept = req_valid && (req_mode == MODE_DRAW);
         end
         ST_BUILD_RD: ;
         ST_BUILD_WR: begin
            cmd.build_write  = 1'b1;
            cmd.build_finish = status.build_done;
         end
         ST_TOT_RD:  cmd.tot_read  = 1'b1;
         ST_TOT_MUL: cmd.mul       = 1'b1;
         ST_NEED:    cmd.need      = 1'b1;
         ST_SRCH:    cmd.srch_read = status.srch_more;
         ST_CMP:     cmd.cmp       = 1'b1;
         ST_DONE:    cmd.rsp_load  = status.rsp_free;
         default: ;
      endcase
   end

endmodule

>>> design/rps_dp.sv
// Datapath: objective and running-sum tables, threshold math, search and result word.
module rps_dp #(
   parameter int MAX_POPULATION = rps_pkg::MAX_POPULATION_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rps_pkg::cmd_type            cmd,
   output rps_pkg::status_type         status,
   input  logic [rps_pkg::OBJ_W-1:0]   req_objective,
   input  logic [rps_pkg::FRAC_W-1:0]  req_random_fraction,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [rps_pkg::INDEX_W-1:0] rsp_parent_index,
   output logic                        rsp_no_table
);
   import rps_pkg::*;

   localparam int IW     = $clog2(MAX_POPULATION);
   localparam int CW     = $clog2(MAX_POPULATION + 1);
   localparam int SW     = OBJ_W + IW;
   localparam int PW     = 2 * FRAC_W;
   localparam int CEIL_W = PW + 1;

   // control state
   logic [CW-1:0]      count_ff, count_in;
   logic [OBJ_W-1:0]   max_ff, max_in;
   logic               ready_ff, ready_in;
   logic               active_ff, active_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload
   logic [IW-1:0]      idx_ff, idx_in;
   logic [SW-1:0]      acc_ff, acc_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic               nt_ff, nt_in;
   logic [SW-1:0]      phi_ff, phi_in;
   logic [PW-1:0]      plo_ff, plo_in;
   logic [SW-1:0]      need_ff, need_in;
   logic [CW-1:0]      lo_ff, lo_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic [IW-1:0]      mid_ff, mid_in;
   logic [INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic               rsp_nt_ff, rsp_nt_in;

   logic [CW-1:0]      eff_count;
   logic [OBJ_W-1:0]   eff_max;
   logic [CW-1:0]      cnt_m1;
   logic               obj_wr_en;
   logic [OBJ_W-1:0]   obj_rdata;
   logic [IW-1:0]      sum_rd_addr;
   logic [SW-1:0]      sum_rdata;
   logic [SW-1:0]      weight;
   logic [CW:0]        mid_sum;
   logic [CEIL_W-1:0]  ceil_sum;
   logic [CW-1:0]      sel_idx;

   assign eff_count = active_ff ? count_ff : '0;
   assign eff_max   = active_ff ? max_ff : '0;
   assign cnt_m1    = count_ff - CW'(1);
   assign obj_wr_en = cmd.load_accept && (eff_count < CW'(MAX_POPULATION));
   assign weight    = SW'(max_ff - obj_rdata);
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_in    = IW'(mid_sum >> 1);
   assign sum_rd_addr = cmd.tot_read ? cnt_m1[IW-1:0] : mid_in;
   assign ceil_sum  = CEIL_W'(plo_ff) + CEIL_W'({FRAC_W{1'b1}});
   assign sel_idx   = (lo_ff >= count_ff) ? cnt_m1 : lo_ff;

   rps_ram #(
      .WIDTH (OBJ_W),
      .DEPTH (MAX_POPULATION)
   ) u_obj_ram (
      .clock   (clock),
      .wr_en   (obj_wr_en),
      .wr_addr (eff_count[IW-1:0]),
      .wr_data (req_objective),
      .rd_addr (idx_ff),
      .rd_data (obj_rdata)
   );

   rps_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_POPULATION)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (cmd.build_write),
      .wr_addr (idx_ff),
      .wr_data (acc_in),
      .rd_addr (sum_rd_addr),
      .rd_data (sum_rdata)
   );

   always_comb begin
      count_in     = count_ff;
      max_in       = max_ff;
      ready_in     = ready_ff;
      active_in    = active_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff + weight;
      frac_in      = frac_ff;
      nt_in        = nt_ff;
      phi_in       = phi_ff;
      plo_in       = plo_ff;
      need_in      = need_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_idx_in   = nt_ff ? '0 : INDEX_W'(sel_idx);
      rsp_nt_in    = nt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.load_accept) begin
         active_in = 1'b1;
         ready_in  = active_ff ? ready_ff : 1'b0;
         count_in  = eff_count;
         max_in    = eff_max;
         if (obj_wr_en) begin
            count_in = eff_count + CW'(1);
            max_in   = (req_objective > eff_max) ? req_objective : eff_max;
         end
         idx_in = '0;
         acc_in = '0;
      end
      if (cmd.build_write) begin
         idx_in = idx_ff + IW'(1);
      end
      if (cmd.build_finish) begin
         ready_in  = (count_ff != '0);
         active_in = 1'b0;
      end
      if (cmd.draw_accept) begin
         frac_in = req_random_fraction;
         nt_in   = !ready_ff;
         lo_in   = '0;
      end
      if (cmd.mul) begin
         phi_in = SW'(frac_ff) * SW'(sum_rdata[SW-1:FRAC_W]);
         plo_in = PW'(frac_ff) * PW'(sum_rdata[FRAC_W-1:0]);
      end
      if (cmd.need) begin
         need_in = phi_ff + SW'(ceil_sum[CEIL_W-1:FRAC_W]);
         lo_in   = '0;
         hi_in   = count_ff;
      end
      if (cmd.cmp) begin
         if (sum_rdata >= need_ff) begin
            hi_in = CW'(mid_ff);
         end else begin
            lo_in = CW'(mid_ff) + CW'(1);
         end
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         max_ff       <= '0;
         ready_ff     <= 1'b0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         max_ff       <= max_in;
         ready_ff     <= ready_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_accept || cmd.build_write) begin
         idx_ff <= idx_in;
         acc_ff <= acc_in;
      end
      if (cmd.srch_read) begin
         mid_ff <= mid_in;
      end
      if (cmd.rsp_load) begin
         rsp_idx_ff <= rsp_idx_in;
         rsp_nt_ff  <= rsp_nt_in;
      end
      frac_ff <= frac_in;
      nt_ff   <= nt_in;
      phi_ff  <= phi_in;
      plo_ff  <= plo_in;
      need_ff <= need_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
   end

   assign status.table_ready = ready_ff;
   assign status.build_done  = (CW'(idx_ff) == cnt_m1);
   assign status.srch_more   = (lo_ff < hi_ff);
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parent_index = rsp_idx_ff;
   assign rsp_no_table     = rsp_nt_ff;

   a_ready_has_entries: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (count_ff != '0))
      else $error("table ready with no entries");

   a_ready_not_loading: assert property (@(posedge clock) disable iff (reset)
      !(ready_ff && active_ff))
      else $error("table ready during a reload");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POPULATION))
      else $error("entry count beyond capacity");

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result word overwritten while held");

endmodule

>>> design/roulette_parent_selector.sv
// Top level of the roulette parent selector (minimization).
// Load word: taken in idle; a load marked last adds a table build that reads, then writes, each stored entry.
// Draw word: the total sum is read and scaled, the threshold formed, and the entry found by
// binary search, which spends one sum-memory read and one compare per step.
// A draw with no table skips the search and goes straight to the result. One word is worked on at a time.
// Synchronous reset clears the entry count, largest objective and table flags; tables are not swept.
module roulette_parent_selector #(
   parameter int MAX_POPULATION = rps_pkg::MAX_POPULATION_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [rps_pkg::OBJ_W-1:0]   req_objective,
   input  logic                        req_last,
   input  logic [rps_pkg::FRAC_W-1:0]  req_random_fraction,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rps_pkg::INDEX_W-1:0] rsp_parent_index,
   output logic                        rsp_no_table
);
   import rps_pkg::*;

   cmd_type    cmd;
   status_type status;

   rps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_last  (req_last),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rps_dp #(
      .MAX_POPULATION (MAX_POPULATION)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_objective       (req_objective),
      .req_random_fraction (req_random_fraction),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_parent_index    (rsp_parent_index),
      .rsp_no_table        (rsp_no_table)
   );

endmodule
